// ----- hw/rtl/pgas_pkg.sv -----
package pgas_pkg;

    localparam int MAX_ELEMS = 8;
    localparam int VAL_W     = $clog2(MAX_ELEMS + 1);
    localparam int CNT_W     = 4;
    localparam int SCAN_W    = $clog2(MAX_ELEMS);
    localparam int WORD_W    = 32;
    localparam int NIB_W     = 4;
    localparam int PACK_N    = (MAX_ELEMS < WORD_W / NIB_W) ? MAX_ELEMS : WORD_W / NIB_W;
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(4);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             load;
        logic             scan;
        logic             update;
        logic [VAL_W-1:0] best;
    } t_cell_ctl;

endpackage

// ----- hw/rtl/pgas_in_if.sv -----
interface pgas_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

// ----- hw/rtl/pgas_out_if.sv -----
interface pgas_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] perm_word;
    logic        moved;
    logic        exhausted;

    modport source (output valid, output perm_word, output moved, output exhausted, input ready);
    modport sink   (input valid, input perm_word, input moved, input exhausted, output ready);
endinterface

// ----- hw/rtl/pgas_cfg_if.sv -----
interface pgas_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] active_count;

    modport source (output valid, output active_count, input ready);
    modport sink   (input valid, input active_count, output ready);
endinterface

// ----- hw/rtl/pgas_cell.sv -----
module pgas_cell import pgas_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [VAL_W-1:0] i_id_val,
    input  logic             i_active,
    input  logic             i_left_ok,
    input  logic             i_right_ok,
    input  logic [VAL_W-1:0] i_left_val,
    input  logic             i_left_dir,
    input  logic [VAL_W-1:0] i_right_val,
    input  logic             i_right_dir,
    input  logic [VAL_W-1:0] i_best,
    output logic [VAL_W-1:0] o_val,
    output logic             o_dir,
    output logic [VAL_W-1:0] o_best
);

    logic [VAL_W-1:0] r_val, n_val;
    logic             r_dir, n_dir;
    logic [VAL_W-1:0] r_best, n_best;
    logic             mobile;
    logic [VAL_W-1:0] cand;
    logic [VAL_W-1:0] sw_val;
    logic             sw_dir;

    always_comb begin
        if (r_dir) begin
            mobile = i_right_ok && (r_val > i_right_val);
        end else begin
            mobile = i_active && i_left_ok && (r_val > i_left_val);
        end
        cand   = mobile ? r_val : '0;
        n_best = (cand > i_best) ? cand : i_best;
    end

    // swap with the neighbor the mobile value points at, then flip larger values
    always_comb begin
        sw_val = r_val;
        sw_dir = r_dir;
        if (r_val == i_ctl.best) begin
            if (r_dir) begin
                sw_val = i_right_val;
                sw_dir = i_right_dir;
            end else begin
                sw_val = i_left_val;
                sw_dir = i_left_dir;
            end
        end else if (i_right_ok && (i_right_val == i_ctl.best) && !i_right_dir) begin
            sw_val = i_right_val;
            sw_dir = i_right_dir;
        end else if (i_left_ok && (i_left_val == i_ctl.best) && i_left_dir) begin
            sw_val = i_left_val;
            sw_dir = i_left_dir;
        end

        n_val = r_val;
        n_dir = r_dir;
        if (i_ctl.load) begin
            n_val = i_id_val;
            n_dir = 1'b0;
        end else if (i_ctl.update) begin
            n_val = sw_val;
            n_dir = sw_dir ^ (i_active && (sw_val > i_ctl.best));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= i_id_val;
            r_dir <= 1'b0;
        end else begin
            r_val <= n_val;
            r_dir <= n_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.scan) begin
            r_best <= n_best;
        end
    end

    assign o_val  = r_val;
    assign o_dir  = r_dir;
    assign o_best = r_best;

endmodule

// ----- hw/rtl/pgas_ctrl.sv -----
module pgas_ctrl import pgas_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_restart,
    input  logic             i_out_free,
    input  logic [VAL_W-1:0] i_best,
    output logic             o_in_ready,
    output t_cell_ctl        o_cell_ctl,
    output logic             o_emit,
    output logic             o_moved,
    output logic             o_exhausted
);

    t_state            r_state, n_state;
    logic [SCAN_W-1:0] r_cnt;
    logic              r_moved;
    logic              r_exh;
    logic              found;
    logic              accept;

    assign found  = (i_best != '0);
    assign accept = (r_state == S_IDLE) && i_in_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_restart ? S_EMIT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == SCAN_W'(MAX_ELEMS - 1)) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: n_state = S_EMIT;
            S_EMIT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready        = 1'b0;
        o_emit            = 1'b0;
        o_cell_ctl.load   = 1'b0;
        o_cell_ctl.scan   = 1'b0;
        o_cell_ctl.update = 1'b0;
        o_cell_ctl.best   = i_best;
        case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cell_ctl.load = i_in_valid && i_restart;
            end
            S_SCAN:   o_cell_ctl.scan   = 1'b1;
            S_UPDATE: o_cell_ctl.update = found;
            S_EMIT:   o_emit            = i_out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_moved <= 1'b0;
            r_exh   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SCAN) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (accept && i_restart) begin
                r_moved <= 1'b1;
                r_exh   <= 1'b0;
            end else if (r_state == S_UPDATE) begin
                r_moved <= found;
                r_exh   <= !found;
            end
        end
    end

    assign o_moved     = r_moved;
    assign o_exhausted = r_exh;

endmodule

// ----- hw/rtl/permutation_gen_adjacent_swap.sv -----
// Adjacent-swap (Johnson-Trotter) permutation generator.
// i_item: one beat per request; restart=1 loads the identity 1..n with all
// directions left, restart=0 advances to the next permutation.
// o_result: one beat per request with perm_word (4 bits per position,
// position 0 lowest, positions n and up zero for n >= 1), moved and exhausted.
// exhausted=1 (moved=0) means no mobile value was left; state is unchanged.
// i_cfg: writes active_count (n); always ready. Write only while idle.
// Sequence: a restart loads the identity, then the result register is loaded;
// a step walks the running maximum along the cell row one cell per cycle,
// then an update state swaps and flips directions, then the result register
// is loaded. One request is in flight at a time; the next is taken in the
// cycle after the result is loaded, even while that result still waits.
// A stalled o_result holds its beat; a finished result waits in the control
// path until the output register is free.
// Reset: identity permutation, directions left, active_count 4, no result.
module permutation_gen_adjacent_swap import pgas_pkg::*; (
    input logic          i_clk,
    input logic          i_rst_n,
    pgas_in_if.sink      i_item,
    pgas_out_if.source   o_result,
    pgas_cfg_if.sink     i_cfg
);

    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_perm;
    logic              r_moved;
    logic              r_exh;
    logic [WORD_W-1:0] pack;
    logic              out_free;
    logic              emit;
    logic              c_moved;
    logic              c_exh;
    t_cell_ctl         ctl;
    logic [MAX_ELEMS-1:0] active;
    logic [VAL_W-1:0]  w_val  [MAX_ELEMS];
    logic              w_dir  [MAX_ELEMS];
    logic [VAL_W-1:0]  w_best [MAX_ELEMS];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (i_cfg.valid) begin
            r_count <= i_cfg.active_count;
        end
    end

    // count 0 acts as one element, counts past the row as the whole row
    always_comb begin
        for (int i = 0; i < MAX_ELEMS; i++) begin
            active[i] = (i == 0) || (i < int'(r_count));
        end
    end

    assign out_free = !r_out_valid || o_result.ready;

    pgas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_restart   (i_item.restart),
        .i_out_free  (out_free),
        .i_best      (w_best[MAX_ELEMS-1]),
        .o_in_ready  (i_item.ready),
        .o_cell_ctl  (ctl),
        .o_emit      (emit),
        .o_moved     (c_moved),
        .o_exhausted (c_exh)
    );

    for (genvar g = 0; g < MAX_ELEMS; g++) begin : g_cell
        pgas_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_id_val    (VAL_W'(g + 1)),
            .i_active    (active[g]),
            .i_left_ok   ((g == 0) ? 1'b0 : 1'b1),
            .i_right_ok  ((g == MAX_ELEMS - 1) ? 1'b0 : active[(g + 1) % MAX_ELEMS]),
            .i_left_val  ((g == 0) ? '0 : w_val[(g + MAX_ELEMS - 1) % MAX_ELEMS]),
            .i_left_dir  ((g == 0) ? 1'b0 : w_dir[(g + MAX_ELEMS - 1) % MAX_ELEMS]),
            .i_right_val ((g == MAX_ELEMS - 1) ? '0 : w_val[(g + 1) % MAX_ELEMS]),
            .i_right_dir ((g == MAX_ELEMS - 1) ? 1'b0 : w_dir[(g + 1) % MAX_ELEMS]),
            .i_best      ((g == 0) ? '0 : w_best[(g + MAX_ELEMS - 1) % MAX_ELEMS]),
            .o_val       (w_val[g]),
            .o_dir       (w_dir[g]),
            .o_best      (w_best[g])
        );
    end

    always_comb begin
        pack = '0;
        for (int i = 0; i < PACK_N; i++) begin
            pack[i*NIB_W +: NIB_W] = active[i] ? NIB_W'(w_val[i]) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_perm  <= pack;
            r_moved <= c_moved;
            r_exh   <= c_exh;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.perm_word = r_perm;
    assign o_result.moved     = r_moved;
    assign o_result.exhausted = r_exh;

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.scan || ctl.update) |-> !i_item.ready)
        else $error("input taken during a step");

    a_restart_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready && i_item.restart)
        |=> (w_val[0] == VAL_W'(1)) && !w_dir[0] && (w_val[MAX_ELEMS-1] == VAL_W'(MAX_ELEMS)))
        else $error("restart did not load identity");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (o_result.moved != o_result.exhausted))
        else $error("moved and exhausted not exclusive");

    a_exhausted_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.scan || (emit && c_exh)) |=> $stable(w_val[0]) && $stable(w_dir[0]))
        else $error("state changed without a swap");

endmodule
